### sv/gmm_pkg.sv
// gmm_pkg: shared types and constants of the gradient magnitude map.
// No dependencies; imported by every module of the block except gmm_ram.
package gmm_pkg;

    localparam int PIX_W   = 8;
    localparam int ROW_W   = 16;
    localparam int COL_W   = 11;
    localparam int FW_W    = 12;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 4;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QLVL_W  = 3;
    localparam int OUT_W   = 40;

    // mapping constants
    localparam logic [PIX_W-1:0] SMALL_LIM  = 8'd5;
    localparam logic [PIX_W-1:0] SMALL_GAIN = 8'd5;
    localparam logic [PIX_W:0]   GRAD_BASE  = 9'd127;
    localparam logic [PIX_W-1:0] GRAD_SAT   = 8'd255;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

    localparam logic [FW_W-1:0]  RST_WIDTH  = 12'd640;
    localparam logic [ROW_W-1:0] RST_HEIGHT = 16'd480;

    // classified pixel leaving the front end
    typedef struct packed {
        logic             calc;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
    } t_item;

    // queue entry: classified pixel plus the two line-store neighbors
    typedef struct packed {
        t_item            item;
        logic [PIX_W-1:0] here;
        logic [PIX_W-1:0] right;
    } t_entry;

endpackage

### sv/gmm_ram.sv
// gmm_ram: generic single-write, single-read RAM with registered read data.
// Read-first on address collision. No package dependency.
module gmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/gmm_front.sv
// gmm_front: pixel intake, row/column counters, classification and
// line-store addressing. Depends on gmm_pkg.
module gmm_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [gmm_pkg::PIX_W-1:0]     i_pixel,
    input  logic [gmm_pkg::FW_W-1:0]      i_frame_width,
    input  logic [gmm_pkg::ROW_W-1:0]     i_frame_height,
    input  logic [gmm_pkg::QLVL_W-1:0]    i_q_level,
    output logic                          o_we,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_addr_here,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_addr_right,
    output logic                          o_s1_valid,
    output gmm_pkg::t_item                o_s1_item
);
    import gmm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = ((CW > FW_W) ? CW : FW_W) + 1;

    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_s1_valid;
    t_item            r_s1_item;

    logic [XW-1:0]    fw_x, max_x, w_m1;
    logic [ROW_W-1:0] h_m1;
    logic             accept, line_end, row_last;
    t_item            item;

    // effective sizes minus one: zero acts as one, width clamps to MAX_WIDTH
    always_comb begin
        fw_x  = XW'(i_frame_width);
        max_x = XW'(MAX_WIDTH);
        if (i_frame_width == '0) begin
            w_m1 = '0;
        end else if (fw_x > max_x) begin
            w_m1 = max_x - XW'(1);
        end else begin
            w_m1 = fw_x - XW'(1);
        end
        h_m1 = (i_frame_height == '0) ? '0 : i_frame_height - ROW_W'(1);
    end

    // room for this pixel and the one already in the read stage
    assign o_ready = ({1'b0, i_q_level} + (QLVL_W + 1)'(r_s1_valid))
                     < (QLVL_W + 1)'(QDEPTH);
    assign accept  = i_valid && o_ready;

    always_comb begin
        line_end  = XW'(r_col) >= w_m1;
        row_last  = r_row >= h_m1;
        item.pix  = i_pixel;
        item.col  = COL_W'(r_col);
        item.last = line_end && row_last;
        item.row  = (r_row == '0) ? h_m1 : r_row - ROW_W'(1);
        item.calc = (r_row != '0) && !line_end && ((r_row - ROW_W'(1)) < h_m1);

        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (line_end) begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    assign o_we         = accept;
    assign o_addr_here  = r_col;
    assign o_addr_right = r_col + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= accept;
        end
        if (accept) begin
            r_s1_item <= item;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_item  = r_s1_item;

endmodule

### sv/gmm_queue.sv
// gmm_queue: small FIFO between the front end and the back end.
// Depends on gmm_pkg.
module gmm_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  gmm_pkg::t_entry            i_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output gmm_pkg::t_entry            o_data,
    output logic [gmm_pkg::QLVL_W-1:0] o_level
);
    import gmm_pkg::*;

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr, n_wptr;
    logic [QPTR_W-1:0]   r_rptr, n_rptr;
    logic [QLVL_W-1:0]   r_level, n_level;

    always_comb begin
        n_wptr  = i_push ? r_wptr + QPTR_W'(1) : r_wptr;
        n_rptr  = i_pop  ? r_rptr + QPTR_W'(1) : r_rptr;
        n_level = r_level + QLVL_W'(i_push) - QLVL_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_level <= n_level;
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_valid = r_level != '0;
    assign o_data  = r_mem[r_rptr];
    assign o_level = r_level;

endmodule

### sv/gmm_back.sv
// gmm_back: gradient computation, magnitude mapping and output register.
// Depends on gmm_pkg.
module gmm_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  gmm_pkg::t_entry           i_entry,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [gmm_pkg::PIX_W-1:0] o_grad,
    output logic [gmm_pkg::ROW_W-1:0] o_row,
    output logic [gmm_pkg::COL_W-1:0] o_col,
    output logic                      o_last
);
    import gmm_pkg::*;

    logic             r_valid;
    logic [PIX_W-1:0] r_grad, n_grad;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             r_last;

    logic [PIX_W-1:0] dh, dv, d;
    logic [PIX_W:0]   sum;

    always_comb begin
        dh  = (i_entry.here > i_entry.right) ? i_entry.here - i_entry.right
                                             : i_entry.right - i_entry.here;
        dv  = (i_entry.here > i_entry.item.pix) ? i_entry.here - i_entry.item.pix
                                                : i_entry.item.pix - i_entry.here;
        d   = (dh > dv) ? dh : dv;
        sum = GRAD_BASE + {1'b0, d};
        if (!i_entry.item.calc) begin
            n_grad = '0;
        end else if (d <= SMALL_LIM) begin
            n_grad = PIX_W'(d * SMALL_GAIN);
        end else if (sum[PIX_W]) begin
            n_grad = GRAD_SAT;
        end else begin
            n_grad = sum[PIX_W-1:0];
        end
    end

    assign o_pop = i_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (o_pop) begin
            r_grad <= n_grad;
            r_row  <= i_entry.item.row;
            r_col  <= i_entry.item.col;
            r_last <= i_entry.item.last;
        end
    end

    assign o_valid = r_valid;
    assign o_grad  = r_grad;
    assign o_row   = r_row;
    assign o_col   = r_col;
    assign o_last  = r_last;

endmodule

### sv/gradient_magnitude_map_unit.sv
// gradient_magnitude_map_unit: top level of the forward-difference gradient map.
// Depends on gmm_pkg, gmm_ram, gmm_front, gmm_queue, gmm_back.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[7:0] pixel
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata grad/row/col, tlast frame_done
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One pixel per clock sustained while the sink keeps up. A transferred pixel passes
// the read stage, the queue and the output register before its result is offered
// on the output stream.
// The line store is two copies of a one-write, one-read RAM so the column and
// its right neighbor from the previous row come out in the same cycle.
// Reset clears counters, queue and output valid; the width and height
// registers return to 640 and 480. The line store is not cleared.
// Sink stalls fill the 4-entry queue; intake stops once it cannot take
// another pixel plus the one already in the read stage.
module gradient_magnitude_map_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // pixel stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [gmm_pkg::PIX_W-1:0]   s_axis_tdata,   // [7:0] pixel
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [gmm_pkg::OUT_W-1:0]   m_axis_tdata,   // [7:0] grad_value,
                                                        // [23:8] out_row,
                                                        // [34:24] out_col, rest 0
    output logic                        m_axis_tlast,   // frame_done
    // configuration writes
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gmm_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [gmm_pkg::CFG_W-1:0]   i_cfg_data
);
    import gmm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [FW_W-1:0]   r_frame_width;
    logic [ROW_W-1:0]  r_frame_height;

    logic              we;
    logic [CW-1:0]     addr_here, addr_right;
    logic [PIX_W-1:0]  rd_here, rd_right;
    logic              s1_valid;
    t_item             s1_item;
    t_entry            push_entry, q_entry;
    logic              q_valid, q_pop;
    logic [QLVL_W-1:0] q_level;
    logic [PIX_W-1:0]  grad;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;

    // configuration: always accepted; the user must see it is taken only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_WIDTH;
            r_frame_height <= RST_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    gmm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_pixel        (s_axis_tdata),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_q_level      (q_level),
        .o_we           (we),
        .o_addr_here    (addr_here),
        .o_addr_right   (addr_right),
        .o_s1_valid     (s1_valid),
        .o_s1_item      (s1_item)
    );

    // both copies take the same write; read-first gives the previous row
    gmm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_here (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr_here),
        .i_wdata (s_axis_tdata),
        .i_raddr (addr_here),
        .o_rdata (rd_here)
    );

    gmm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_right (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr_here),
        .i_wdata (s_axis_tdata),
        .i_raddr (addr_right),
        .o_rdata (rd_right)
    );

    always_comb begin
        push_entry.item  = s1_item;
        push_entry.here  = rd_here;
        push_entry.right = rd_right;
    end

    gmm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s1_valid),
        .i_data  (push_entry),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_entry),
        .o_level (q_level)
    );

    gmm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (q_entry),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_grad  (grad),
        .o_row   (row),
        .o_col   (col),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_W - PIX_W - ROW_W - COL_W){1'b0}}, col, row, grad};

    // queue never receives an entry it has no room for
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && !q_pop) |-> (q_level < QLVL_W'(QDEPTH)))
        else $error("line queue overflow");

    // back end pops only real entries
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_level != '0))
        else $error("line queue underflow");

    // intake stalls whenever the queue plus read stage could fill up
    a_intake_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (q_level < QLVL_W'(QDEPTH)))
        else $error("pixel accepted without queue room");

    // frame end lies in the last column, whose gradient is zero
    a_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[PIX_W-1:0] == '0))
        else $error("nonzero gradient on frame end");

endmodule

### sim/gradient_magnitude_map_unit_tb.sv
`timescale 1ns / 1ps
// gradient_magnitude_map_unit_tb: self-checking bench for the gradient map unit.
// Needs gmm_pkg and gradient_magnitude_map_unit; predicts every result in the bench
// and compares each output transfer against the oldest prediction.
module gradient_magnitude_map_unit_tb;

    localparam int MAX_W        = 2048;      // line store depth of the unit instance
    localparam int CYCLE_LIMIT  = 2_000_000; // several times the slowest legal run
    localparam int RANDOM_ITEMS = 540;

    // an index outside the register map, the unit must ignore it
    localparam logic [gmm_pkg::IDX_W-1:0] REG_UNMAPPED = 4'hE;

    // one predicted output transfer
    typedef struct {
        logic [gmm_pkg::PIX_W-1:0] grad;
        logic [gmm_pkg::ROW_W-1:0] row;
        logic [gmm_pkg::COL_W-1:0] col;
        logic                      done;
    } grad_res_t;

    // content style of a generated frame
    typedef enum int {PIX_NOISE, PIX_FLAT, PIX_EXTREME, PIX_TEXTURE} pix_style_e;

    // ---------------------------------------------------------------- DUT hookup
    logic                        i_clk     = 1'b0;
    logic                        i_rst_n   = 1'b0;
    logic                        s_tvalid  = 1'b0;
    logic [gmm_pkg::PIX_W-1:0]   s_tdata   = '0;
    wire                         s_tready;
    wire                         m_tvalid;
    logic                        m_tready  = 1'b0;
    wire  [gmm_pkg::OUT_W-1:0]   m_tdata;
    wire                         m_tlast;
    logic                        cfg_valid = 1'b0;
    wire                         cfg_ready;
    logic [gmm_pkg::IDX_W-1:0]   cfg_index = '0;
    logic [gmm_pkg::CFG_W-1:0]   cfg_data  = '0;

    gradient_magnitude_map_unit #(
        .MAX_WIDTH     (MAX_W)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- bench state
    // Register shadow. Only written while the unit is idle, so the generator and
    // the predictor can share one copy.
    logic [gmm_pkg::FW_W-1:0]  cfg_width  = gmm_pkg::RST_WIDTH;
    logic [gmm_pkg::ROW_W-1:0] cfg_height = gmm_pkg::RST_HEIGHT;

    bit [gmm_pkg::PIX_W-1:0] line_mem [MAX_W];   // previous-row shadow
    int unsigned pred_col = 0, pred_row = 0;     // position of next accepted pixel
    int unsigned gen_col  = 0, gen_row  = 0;     // position of next queued pixel

    logic [gmm_pkg::PIX_W-1:0] pixel_q [$];      // pixels waiting for the driver
    grad_res_t                 grad_expected [$];

    int unsigned n_sent    = 0;  // pixels queued
    int unsigned n_checked = 0;  // results compared
    int          fail_count = 0;
    int unsigned cycle_cnt = 0;

    bit          idle_on  = 1'b1;  // random gaps on both sides
    bit          hold_arm = 1'b0;  // asks the sink for one long hold-off
    int          tx_gap   = 0;
    int          rx_stall = 0;

    pix_style_e              pix_style = PIX_NOISE;
    logic [gmm_pkg::PIX_W-1:0] pix_base = '0;

    // ---------------------------------------------------------------- helpers
    function automatic int unsigned eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_W) return MAX_W;
        return 32'(cfg_width);
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height == 0) ? 1 : 32'(cfg_height);
    endfunction

    function automatic int unsigned absdiff(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Raster walk; counters left past a shrunk size wrap at the next input.
    function automatic void advance_pos(inout int unsigned col, inout int unsigned row);
        if (col >= eff_width() - 1) begin
            col = 0;
            row = (row >= eff_height() - 1) ? 0 : row + 1;
        end else begin
            col = col + 1;
        end
    endfunction

    // Result caused by one accepted pixel; updates the line shadow and position.
    function automatic grad_res_t predict_grad(input logic [gmm_pkg::PIX_W-1:0] px);
        grad_res_t   res;
        int unsigned w, h, dh, dv, d;
        bit          line_end;
        w        = eff_width();
        h        = eff_height();
        line_end = (pred_col >= w - 1);
        res.grad = '0;
        res.col  = gmm_pkg::COL_W'(pred_col);
        res.done = line_end && (pred_row >= h - 1);
        if (pred_row == 0) begin
            // row 0 answers with the zero border of the frame's last row
            res.row = gmm_pkg::ROW_W'(h - 1);
        end else begin
            res.row = gmm_pkg::ROW_W'(pred_row - 1);
            if (!line_end && (pred_row - 1 < h - 1) && (pred_col + 1 < MAX_W)) begin
                dh = absdiff(32'(line_mem[pred_col]), 32'(line_mem[pred_col + 1]));
                dv = absdiff(32'(line_mem[pred_col]), 32'(px));
                d  = (dh > dv) ? dh : dv;
                // small slopes scaled by 5, larger ones offset by 127 and clipped
                if (d <= 5)
                    res.grad = gmm_pkg::PIX_W'(5 * d);
                else
                    res.grad = (d + 127 > 255) ? 8'd255 : gmm_pkg::PIX_W'(d + 127);
            end
        end
        if (pred_col < MAX_W) line_mem[pred_col] = px;
        advance_pos(pred_col, pred_row);
        return res;
    endfunction

    // Mostly short gaps, a few long ones; none while idling is off.
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // ---------------------------------------------------------------- pixel driver
    // Predicts on each accepted transfer, then refills the slot from pixel_q.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                grad_expected.push_back(predict_grad(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    s_tdata  <= pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    tx_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- result monitor
    always @(posedge i_clk) begin
        grad_res_t want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (grad_expected.size() == 0) begin
                    $error("result with nothing pending: row %0d col %0d",
                           m_tdata[gmm_pkg::PIX_W +: gmm_pkg::ROW_W],
                           m_tdata[gmm_pkg::PIX_W + gmm_pkg::ROW_W +: gmm_pkg::COL_W]);
                    fail_count++;
                end else begin
                    want = grad_expected.pop_front();
                    check_field("grad_value", want.grad, m_tdata[gmm_pkg::PIX_W-1:0]);
                    check_field("out_row", want.row,
                                m_tdata[gmm_pkg::PIX_W +: gmm_pkg::ROW_W]);
                    check_field("out_col", want.col,
                                m_tdata[gmm_pkg::PIX_W + gmm_pkg::ROW_W +: gmm_pkg::COL_W]);
                    check_field("frame_done", want.done, m_tlast);
                    n_checked++;
                end
            end
            // long hold-off: the queue fills and intake must stall
            if (hold_arm) begin
                hold_arm = 1'b0;
                rx_stall = 400;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                rx_stall = pick_gap();
                m_tready <= (rx_stall == 0);
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[gradient_magnitude_map_unit] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic write_reg(input logic [gmm_pkg::IDX_W-1:0] idx,
                             input logic [gmm_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            gmm_pkg::REG_FRAME_WIDTH:  cfg_width  = val[gmm_pkg::FW_W-1:0];
            gmm_pkg::REG_FRAME_HEIGHT: cfg_height = val;
            default: ;
        endcase
    endtask

    // Every pixel has one result, so idle means all queued pixels were answered.
    task automatic wait_idle();
        while (n_checked != n_sent) @(posedge i_clk);
    endtask

    task automatic push_pixel(input logic [gmm_pkg::PIX_W-1:0] px);
        pixel_q.push_back(px);
        n_sent++;
        advance_pos(gen_col, gen_row);
    endtask

    task automatic new_frame_style();
        pix_style = pix_style_e'($urandom_range(0, 3));
        pix_base  = (pix_style == PIX_FLAT) ? gmm_pkg::PIX_W'($urandom_range(0, 250))
                                            : gmm_pkg::PIX_W'($urandom_range(0, 215));
    endtask

    function automatic logic [gmm_pkg::PIX_W-1:0] make_pixel();
        case (pix_style)
            PIX_NOISE:   return gmm_pkg::PIX_W'($urandom_range(0, 255));
            PIX_FLAT:    return pix_base + gmm_pkg::PIX_W'($urandom_range(0, 5)); // slopes 0..5
            PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:     return pix_base + gmm_pkg::PIX_W'($urandom_range(0, 40));
        endcase
    endfunction

    task automatic finish_frame();
        while (gen_col != 0 || gen_row != 0) push_pixel(make_pixel());
    endtask

    task automatic run_frames(input int n_frames);
        repeat (n_frames) begin
            new_frame_style();
            push_pixel(make_pixel());
            finish_frame();
        end
    endtask

    initial begin
        int unsigned n_random, n_mark, w, h, r;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // reset geometry 640x480: row 0 answers with zeros of row 479
        push_pixel(8'd0);
        push_pixel(8'd255);
        push_pixel(8'd128);
        wait_idle();

        // width shrunk mid-line: column 3 already sits at the new line end
        write_reg(gmm_pkg::REG_FRAME_WIDTH, 16'd4);
        write_reg(gmm_pkg::REG_FRAME_HEIGHT, 16'd3);
        push_pixel(8'd10);
        push_pixel(8'd13);  push_pixel(8'd12);  push_pixel(8'd255); push_pixel(8'd0);
        push_pixel(8'd14);  push_pixel(8'd10);  push_pixel(8'd250); push_pixel(8'd3);
        wait_idle();

        // zero width and height act as one: single pixel frames
        write_reg(gmm_pkg::REG_FRAME_WIDTH, 16'd0);
        write_reg(gmm_pkg::REG_FRAME_HEIGHT, 16'd0);
        push_pixel(8'd0);
        push_pixel(8'd255);
        push_pixel(8'd7);
        wait_idle();

        // upper data bits ignored by the width register; unmapped index ignored
        write_reg(gmm_pkg::REG_FRAME_WIDTH, 16'hF003);
        write_reg(gmm_pkg::REG_FRAME_HEIGHT, 16'd2);
        write_reg(REG_UNMAPPED, 16'hFFFF);
        push_pixel(8'd100); push_pixel(8'd105); push_pixel(8'd0);
        push_pixel(8'd100); push_pixel(8'd94);  push_pixel(8'd255);
        wait_idle();

        // --- widest setting: 4095 clips to the store depth, sink holds off ---
        idle_on = 1'b1;
        write_reg(gmm_pkg::REG_FRAME_WIDTH, 16'h0FFF);
        write_reg(gmm_pkg::REG_FRAME_HEIGHT, 16'd2);
        new_frame_style();
        hold_arm = 1'b1;    // sink holds off while the source keeps offering
        repeat (50) push_pixel(make_pixel());
        wait_idle();
        // line narrowed behind the current column: wraps at the next input
        write_reg(gmm_pkg::REG_FRAME_WIDTH, 16'd8);
        finish_frame();
        wait_idle();

        // --- tallest frame, then height shrunk below the current row ---
        write_reg(gmm_pkg::REG_FRAME_WIDTH, 16'd2);
        write_reg(gmm_pkg::REG_FRAME_HEIGHT, 16'hFFFF);
        new_frame_style();
        repeat (20) push_pixel(make_pixel());
        wait_idle();
        write_reg(gmm_pkg::REG_FRAME_HEIGHT, 16'd5);
        finish_frame();
        wait_idle();

        // --- random frames ---
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 9);
            if (r < 5)      w = $urandom_range(1, 8);
            else if (r < 8) w = $urandom_range(9, 32);
            else if (r < 9) w = $urandom_range(33, 100);
            else            w = 0;
            r = $urandom_range(0, 9);
            if (r == 0)     h = 0;
            else if (r < 8) h = $urandom_range(1, 5);
            else            h = $urandom_range(6, 12);
            write_reg(gmm_pkg::REG_FRAME_WIDTH,
                      {4'($urandom_range(0, 15)), gmm_pkg::FW_W'(w)});
            write_reg(gmm_pkg::REG_FRAME_HEIGHT, gmm_pkg::CFG_W'(h));
            n_mark = n_sent;
            if ($urandom_range(0, 4) == 0) begin
                // stop partway, narrow the line with counters mid-frame
                new_frame_style();
                repeat ($urandom_range(1, eff_width() * eff_height()))
                    push_pixel(make_pixel());
                wait_idle();
                write_reg(gmm_pkg::REG_FRAME_WIDTH,
                          gmm_pkg::CFG_W'($urandom_range(0, eff_width())));
                finish_frame();
            end else begin
                run_frames($urandom_range(1, 3));
            end
            wait_idle();
            n_random += n_sent - n_mark;
        end

        // --- drain ---
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && grad_expected.size() == 0) begin
            $display("[gradient_magnitude_map_unit] OK");
        end else begin
            $display("[gradient_magnitude_map_unit] ERROR");
        end
        $finish;
    end

endmodule
